>>> sv/nct_pkg.sv
package nct_pkg;

    localparam int CLIENT_DEPTH_DEF = 8;
    localparam int CONN_DEPTH_DEF   = 32;

    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int PROTO_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;

    localparam logic [MAC_W-1:0]   OWN_MAC_RST     = 48'h0;
    localparam logic [IP_W-1:0]    OWN_IP_RST      = 32'h0;
    localparam logic [MAC_W-1:0]   GATEWAY_MAC_RST = 48'hA6171CEEB16F;
    localparam logic [MAC_W-1:0]   REPLY_MAC_RST   = 48'hFFFFFFFFFFFF;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    localparam logic OP_OUTBOUND = 1'b0;
    localparam logic OP_INBOUND  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_MAC       = 2'd0,
        CFG_OWN_IP        = 2'd1,
        CFG_GATEWAY_MAC   = 2'd2,
        CFG_REPLY_SRC_MAC = 2'd3
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXISTING    = 3'd0,
        ST_NEW_CONN    = 3'd1,
        ST_NEW_CLIENT  = 3'd2,
        ST_CLIENT_FULL = 3'd3,
        ST_CONN_FULL   = 3'd4,
        ST_NO_CLIENT   = 3'd5,
        ST_NO_CONN     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CSCAN,
        S_KSCAN
    } state_t;

    typedef struct packed {
        logic               operation;
        logic [PROTO_W-1:0] protocol;
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    dst_ip;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
        logic [MAC_W-1:0]   src_mac;
    } pkt_in_t;

    typedef struct packed {
        logic                forward;
        logic [MAC_W-1:0]    out_dst_mac;
        logic [MAC_W-1:0]    out_src_mac;
        logic [IP_W-1:0]     out_src_ip;
        logic [STATUS_W-1:0] status;
    } pkt_out_t;

    typedef struct packed {
        logic    load;
        logic    scan_clr;
        logic    scan_step;
        logic    scan_conn;
        logic    client_wr;
        logic    conn_wr;
        logic    res_valid;
        logic    res_fwd;
        status_t res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic inbound;
        logic scan_done;
        logic scan_hit;
        logic client_full;
        logic conn_full;
    } dp_stat_t;

endpackage

>>> sv/nct_ram.sv
module nct_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/nct_ctrl.sv
module nct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  nct_pkg::dp_stat_t stat,
    output nct_pkg::dp_cmd_t  cmd
);
    import nct_pkg::*;

    state_t state_reg, state_next;
    logic   added_reg, added_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            added_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            added_reg <= added_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        added_next     = added_reg;
        cmd            = '0;
        cmd.res_status = ST_EXISTING;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    added_next   = 1'b0;
                    state_next   = S_CSCAN;
                end
            end
            S_CSCAN:
            begin
                if (!stat.scan_done)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (stat.scan_hit)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_KSCAN;
                end
                else if (stat.inbound)
                begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_NO_CLIENT;
                    state_next     = S_IDLE;
                end
                else if (stat.client_full)
                begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_CLIENT_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.client_wr = 1'b1;
                    cmd.scan_clr  = 1'b1;
                    added_next    = 1'b1;
                    state_next    = S_KSCAN;
                end
            end
            S_KSCAN:
            begin
                cmd.scan_conn = 1'b1;
                if (!stat.scan_done)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    cmd.res_valid = 1'b1;
                    state_next    = S_IDLE;
                    if (stat.scan_hit)
                    begin
                        cmd.res_fwd    = 1'b1;
                        cmd.res_status = (!stat.inbound && added_reg) ? ST_NEW_CLIENT
                                                                      : ST_EXISTING;
                    end
                    else if (stat.inbound)
                    begin
                        cmd.res_status = ST_NO_CONN;
                    end
                    else if (stat.conn_full)
                    begin
                        cmd.res_status = ST_CONN_FULL;
                    end
                    else
                    begin
                        cmd.conn_wr    = 1'b1;
                        cmd.res_fwd    = 1'b1;
                        cmd.res_status = added_reg ? ST_NEW_CLIENT : ST_NEW_CONN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> sv/nct_dpath.sv
module nct_dpath #(
    parameter int CLIENT_DEPTH = nct_pkg::CLIENT_DEPTH_DEF,
    parameter int CONN_DEPTH   = nct_pkg::CONN_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nct_pkg::pkt_in_t               request,
    input  logic                           cfg_valid,
    input  logic [nct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nct_pkg::CFG_W-1:0]      cfg_data,
    input  nct_pkg::dp_cmd_t               cmd,
    output nct_pkg::dp_stat_t              stat,
    output logic                           done,
    output nct_pkg::pkt_out_t              result
);
    import nct_pkg::*;

    localparam int CLI_IDX_W  = (CLIENT_DEPTH > 1) ? $clog2(CLIENT_DEPTH) : 1;
    localparam int CLI_CNT_W  = $clog2(CLIENT_DEPTH + 1);
    localparam int CONN_IDX_W = (CONN_DEPTH > 1) ? $clog2(CONN_DEPTH) : 1;
    localparam int CONN_CNT_W = $clog2(CONN_DEPTH + 1);
    localparam int SCAN_W     = (CONN_CNT_W > CLI_CNT_W) ? CONN_CNT_W : CLI_CNT_W;
    localparam int CLI_W      = IP_W + MAC_W;
    localparam int CONN_W     = CLI_IDX_W + PORT_W + IP_W + PORT_W;

    // configuration
    logic [MAC_W-1:0] own_mac_reg, gateway_mac_reg, reply_mac_reg;
    logic [IP_W-1:0]  own_ip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg     <= OWN_MAC_RST;
            own_ip_reg      <= OWN_IP_RST;
            gateway_mac_reg <= GATEWAY_MAC_RST;
            reply_mac_reg   <= REPLY_MAC_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_OWN_MAC:       own_mac_reg     <= cfg_data;
                CFG_OWN_IP:        own_ip_reg      <= cfg_data[IP_W-1:0];
                CFG_GATEWAY_MAC:   gateway_mac_reg <= cfg_data;
                CFG_REPLY_SRC_MAC: reply_mac_reg   <= cfg_data;
                default:           own_mac_reg     <= own_mac_reg;
            endcase
        end
    end

    // latched packet, ports zeroed unless TCP or UDP
    logic              op_reg;
    logic [IP_W-1:0]   sip_reg, dip_reg;
    logic [PORT_W-1:0] sport_reg, dport_reg;
    logic [MAC_W-1:0]  smac_reg;
    logic              use_ports;

    assign use_ports = (request.protocol == PROTO_TCP) || (request.protocol == PROTO_UDP);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= request.operation;
            sip_reg   <= request.src_ip;
            dip_reg   <= request.dst_ip;
            sport_reg <= use_ports ? request.sport : '0;
            dport_reg <= use_ports ? request.dport : '0;
            smac_reg  <= request.src_mac;
        end
    end

    logic              inbound;
    logic [IP_W-1:0]   cli_key;
    logic [IP_W-1:0]   rip_key;
    logic [PORT_W-1:0] rport_key;

    assign inbound   = (op_reg == OP_INBOUND);
    assign cli_key   = inbound ? dip_reg : sip_reg;
    assign rip_key   = inbound ? sip_reg : dip_reg;
    assign rport_key = inbound ? sport_reg : dport_reg;

    // fill counts: slots fill from the bottom and are never freed
    logic [CLI_CNT_W-1:0]  cli_count_reg, cli_count_next;
    logic [CONN_CNT_W-1:0] conn_count_reg, conn_count_next;

    // scan state
    logic [SCAN_W-1:0]    addr_reg, addr_next, pend_idx_reg, pend_idx_next;
    logic                 pend_reg, pend_next, hit_reg, hit_next;
    logic [CLI_IDX_W-1:0] cli_idx_reg, cli_idx_next;
    logic [MAC_W-1:0]     cli_mac_reg, cli_mac_next;

    logic [SCAN_W-1:0] limit;
    logic              issue, cli_match, conn_match, match;
    logic [CLI_W-1:0]  cli_rd;
    logic [CONN_W-1:0] conn_rd, conn_wdata;

    assign limit = cmd.scan_conn ? SCAN_W'(conn_count_reg) : SCAN_W'(cli_count_reg);
    assign issue = cmd.scan_step && !hit_reg && (addr_reg < limit);

    assign cli_match  = (cli_rd[CLI_W-1 -: IP_W] == cli_key);
    assign conn_match = (conn_rd[CONN_W-1 -: CLI_IDX_W] == cli_idx_reg) &&
                        (conn_rd[PORT_W +: IP_W] == rip_key) &&
                        (conn_rd[PORT_W-1:0] == rport_key);
    assign match      = pend_reg && !hit_reg && (cmd.scan_conn ? conn_match : cli_match);

    assign conn_wdata = {cli_idx_reg, sport_reg, dip_reg, dport_reg};

    always_comb
    begin
        addr_next       = addr_reg;
        pend_next       = issue;
        pend_idx_next   = addr_reg;
        hit_next        = hit_reg;
        cli_idx_next    = cli_idx_reg;
        cli_mac_next    = cli_mac_reg;
        cli_count_next  = cli_count_reg;
        conn_count_next = conn_count_reg;
        if (issue)
        begin
            addr_next = addr_reg + SCAN_W'(1);
        end
        if (match)
        begin
            hit_next = 1'b1;
            if (!cmd.scan_conn)
            begin
                cli_idx_next = pend_idx_reg[CLI_IDX_W-1:0];
                cli_mac_next = cli_rd[MAC_W-1:0];
            end
        end
        if (cmd.scan_clr)
        begin
            addr_next = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
        end
        if (cmd.client_wr)
        begin
            cli_idx_next   = cli_count_reg[CLI_IDX_W-1:0];
            cli_count_next = cli_count_reg + CLI_CNT_W'(1);
        end
        if (cmd.conn_wr)
        begin
            conn_count_next = conn_count_reg + CONN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            cli_count_reg  <= '0;
            conn_count_reg <= '0;
        end
        else
        begin
            addr_reg       <= addr_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            cli_count_reg  <= cli_count_next;
            conn_count_reg <= conn_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        cli_idx_reg  <= cli_idx_next;
        cli_mac_reg  <= cli_mac_next;
    end

    nct_ram #(
        .WIDTH (CLI_W),
        .DEPTH (CLIENT_DEPTH)
    ) u_client_ram (
        .clk     (clk),
        .wr_en   (cmd.client_wr),
        .wr_addr (cli_count_reg[CLI_IDX_W-1:0]),
        .wr_data ({sip_reg, smac_reg}),
        .rd_en   (issue && !cmd.scan_conn),
        .rd_addr (addr_reg[CLI_IDX_W-1:0]),
        .rd_data (cli_rd)
    );

    nct_ram #(
        .WIDTH (CONN_W),
        .DEPTH (CONN_DEPTH)
    ) u_conn_ram (
        .clk     (clk),
        .wr_en   (cmd.conn_wr),
        .wr_addr (conn_count_reg[CONN_IDX_W-1:0]),
        .wr_data (conn_wdata),
        .rd_en   (issue && cmd.scan_conn),
        .rd_addr (addr_reg[CONN_IDX_W-1:0]),
        .rd_data (conn_rd)
    );

    assign stat.inbound     = inbound;
    assign stat.scan_done   = hit_reg || (!pend_reg && (addr_reg >= limit));
    assign stat.scan_hit    = hit_reg;
    assign stat.client_full = (cli_count_reg == CLI_CNT_W'(CLIENT_DEPTH));
    assign stat.conn_full   = (conn_count_reg == CONN_CNT_W'(CONN_DEPTH));

    // result word
    logic     done_reg;
    pkt_out_t result_reg, result_next;

    always_comb
    begin
        result_next        = '0;
        result_next.status = cmd.res_status;
        if (cmd.res_fwd)
        begin
            result_next.forward     = 1'b1;
            result_next.out_dst_mac = inbound ? cli_mac_reg : gateway_mac_reg;
            result_next.out_src_mac = inbound ? reply_mac_reg : own_mac_reg;
            result_next.out_src_ip  = own_ip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> sv/nat_connection_tracker.sv
// channel   | direction | signals                                   | word taken when
// ----------+-----------+-------------------------------------------+----------------------
// request   | in        | start, busy, request                      | start && !busy
// result    | out       | done, result                              | done (one cycle)
// config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One packet at a time: the client table is searched first, then the connection table.
// done rises once the last search has ended; the result word is registered.
// Each table is searched one entry a cycle through the registered read port of its RAM:
// a hit ends a search early; a drop for lack of a client ends the packet after the first.
// busy falls as done rises, so the next word can be taken while the result is shown.
// Reset clears the fill counts, not the tables, so no clearing pass runs; the receiver cannot stall.
module nat_connection_tracker #(
    parameter int CLIENT_DEPTH = nct_pkg::CLIENT_DEPTH_DEF,
    parameter int CONN_DEPTH   = nct_pkg::CONN_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nct_pkg::pkt_in_t              request,
    output logic                          done,
    output nct_pkg::pkt_out_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nct_pkg::CFG_W-1:0]     cfg_data
);
    import nct_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    nct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    nct_dpath #(
        .CLIENT_DEPTH (CLIENT_DEPTH),
        .CONN_DEPTH   (CONN_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

>>> sv/nct_checker.sv
module nct_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input nct_pkg::pkt_out_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work finished without a result word");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.forward |->
            (result.out_dst_mac == '0) && (result.out_src_mac == '0) &&
            (result.out_src_ip == '0))
        else $error("dropped word carries rewritten fields");

    a_fwd_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.forward |->
            (result.status == nct_pkg::ST_EXISTING) ||
            (result.status == nct_pkg::ST_NEW_CONN) ||
            (result.status == nct_pkg::ST_NEW_CLIENT))
        else $error("forwarded word with a drop status");

endmodule

bind nat_connection_tracker nct_checker u_nct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> bench/testbench.sv
module testbench;
    import nct_pkg::*;

    localparam int CLIENTS        = CLIENT_DEPTH_DEF;
    localparam int CONNS          = CONN_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 600;
    localparam int PHASES         = 3;
    localparam int HOST_POOL      = 10;
    localparam int PEER_POOL      = 6;
    localparam int PORT_POOL      = 4;
    localparam int RECENT         = 16;
    localparam int SETTLE_CYCLES  = 60;

    localparam logic [IP_W-1:0]  HOST_A  = 32'h0A00_0001;
    localparam logic [IP_W-1:0]  HOST_B  = 32'h0A00_0002;
    localparam logic [IP_W-1:0]  PEER_IP = 32'h0808_0808;
    localparam logic [IP_W-1:0]  DNS_IP  = 32'h0101_0101;
    localparam logic [MAC_W-1:0] MAC_A   = 48'h0200_0000_00AA;
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    pkt_in_t           request;
    logic              done;
    pkt_out_t          result;
    logic              cfg_valid;
    logic              cfg_ready;
    cfg_reg_t          cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    // typed-in expectation travelling with the request word
    logic              req_typed;
    pkt_out_t          req_want;

    nat_connection_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tracker shadow state
    logic [MAC_W-1:0]  cur_own_mac     = OWN_MAC_RST;
    logic [IP_W-1:0]   cur_own_ip      = OWN_IP_RST;
    logic [MAC_W-1:0]  cur_gateway_mac = GATEWAY_MAC_RST;
    logic [MAC_W-1:0]  cur_reply_mac   = REPLY_MAC_RST;
    logic [IP_W-1:0]   host_ip   [CLIENTS];
    logic [MAC_W-1:0]  host_mac  [CLIENTS];
    int                host_count = 0;
    int                flow_owner     [CONNS];
    logic [IP_W-1:0]   flow_peer_ip   [CONNS];
    logic [PORT_W-1:0] flow_peer_port [CONNS];
    bit                flow_live      [CONNS];

    pkt_out_t          expected_q [$];
    int                n_taken = 0;
    int                n_done  = 0;
    int                n_fwd   = 0;
    int                n_cfg   = 0;
    int                n_bad   = 0;
    int                quiet_cycles = 0;
    int                status_seen [8];

    typedef struct {
        pkt_in_t  pkt;
        bit       typed;
        pkt_out_t want;
    } step_row_t;

    step_row_t         script [$];

    logic [IP_W-1:0]   pool_host_ip  [HOST_POOL];
    logic [MAC_W-1:0]  pool_host_mac [HOST_POOL];
    logic [IP_W-1:0]   pool_peer_ip  [PEER_POOL];
    logic [PORT_W-1:0] pool_port     [PORT_POOL];
    pkt_in_t           recent_out    [RECENT];
    int                recent_wr = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int find_host(input logic [IP_W-1:0] ip);
        int hit;
        hit = -1;
        for (int i = CLIENTS - 1; i >= 0; i--)
            if (i < host_count && host_ip[i] == ip)
                hit = i;
        return hit;
    endfunction

    function automatic int find_flow(input int owner, input logic [IP_W-1:0] ip,
                                     input logic [PORT_W-1:0] port);
        int hit;
        hit = -1;
        for (int i = CONNS - 1; i >= 0; i--)
            if (flow_live[i] && flow_owner[i] == owner && flow_peer_ip[i] == ip &&
                flow_peer_port[i] == port)
                hit = i;
        return hit;
    endfunction

    function automatic pkt_out_t track_packet(input pkt_in_t p);
        pkt_out_t          r;
        logic [PORT_W-1:0] sport;
        logic [PORT_W-1:0] dport;
        logic [MAC_W-1:0]  dmac;
        logic [MAC_W-1:0]  smac;
        status_t           st;
        bit                fwd;
        bit                added;
        int                h;
        int                f;
        r     = '0;
        st    = ST_EXISTING;
        fwd   = 1'b0;
        added = 1'b0;
        dmac  = '0;
        smac  = '0;
        // ports only count for TCP and UDP
        sport = (p.protocol == PROTO_TCP || p.protocol == PROTO_UDP) ? p.sport : '0;
        dport = (p.protocol == PROTO_TCP || p.protocol == PROTO_UDP) ? p.dport : '0;
        if (p.operation == OP_OUTBOUND) begin
            h = find_host(p.src_ip);
            if (h < 0 && host_count >= CLIENTS) begin
                st = ST_CLIENT_FULL;
            end
            else begin
                if (h < 0) begin
                    h = host_count;
                    host_ip[h]  = p.src_ip;
                    host_mac[h] = p.src_mac;
                    host_count++;
                    added = 1'b1;
                end
                f = find_flow(h, p.dst_ip, dport);
                if (f >= 0) begin
                    st = added ? ST_NEW_CLIENT : ST_EXISTING;
                end
                else begin
                    for (int i = CONNS - 1; i >= 0; i--)
                        if (!flow_live[i])
                            f = i;
                    if (f < 0) begin
                        st = ST_CONN_FULL;
                    end
                    else begin
                        flow_live[f]      = 1'b1;
                        flow_owner[f]     = h;
                        flow_peer_ip[f]   = p.dst_ip;
                        flow_peer_port[f] = dport;
                        st = added ? ST_NEW_CLIENT : ST_NEW_CONN;
                    end
                end
                fwd  = (f >= 0);
                dmac = cur_gateway_mac;
                smac = cur_own_mac;
            end
        end
        else begin
            h = find_host(p.dst_ip);
            if (h < 0) begin
                st = ST_NO_CLIENT;
            end
            else begin
                f = find_flow(h, p.src_ip, sport);
                if (f < 0) begin
                    st = ST_NO_CONN;
                end
                else begin
                    st   = ST_EXISTING;
                    fwd  = 1'b1;
                    dmac = host_mac[h];
                    smac = cur_reply_mac;
                end
            end
        end
        r.forward = fwd;
        if (fwd) begin
            r.out_dst_mac = dmac;
            r.out_src_mac = smac;
            r.out_src_ip  = cur_own_ip;
        end
        r.status = st;
        return r;
    endfunction

    function automatic pkt_in_t mk_pkt(input logic op, input logic [PROTO_W-1:0] proto,
                                       input logic [IP_W-1:0] sip, input logic [IP_W-1:0] dip,
                                       input logic [PORT_W-1:0] sp,
                                       input logic [PORT_W-1:0] dp,
                                       input logic [MAC_W-1:0] mac);
        pkt_in_t p;
        p.operation = op;
        p.protocol  = proto;
        p.src_ip    = sip;
        p.dst_ip    = dip;
        p.sport     = sp;
        p.dport     = dp;
        p.src_mac   = mac;
        return p;
    endfunction

    // forwarded word under reset settings
    function automatic pkt_out_t fwd_word(input logic [MAC_W-1:0] dmac,
                                          input logic [MAC_W-1:0] smac, input status_t st);
        pkt_out_t r;
        r.forward     = 1'b1;
        r.out_dst_mac = dmac;
        r.out_src_mac = smac;
        r.out_src_ip  = OWN_IP_RST;
        r.status      = st;
        return r;
    endfunction

    function automatic pkt_out_t drop_word(input status_t st);
        pkt_out_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    task automatic add_step(input pkt_in_t p, input bit typed, input pkt_out_t want);
        step_row_t row;
        row.pkt   = p;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endtask

    function automatic logic [PROTO_W-1:0] pick_protocol();
        int roll;
        roll = $urandom_range(9);
        if (roll < 4)
            return PROTO_TCP;
        else if (roll < 8)
            return PROTO_UDP;
        return PROTO_W'($urandom_range(255));
    endfunction

    function automatic pkt_in_t random_packet();
        pkt_in_t p;
        pkt_in_t q;
        int      roll;
        int      k;
        roll       = $urandom_range(99);
        p.operation = OP_INBOUND;
        p.protocol  = pick_protocol();
        p.src_ip    = $urandom;
        p.dst_ip    = $urandom;
        p.sport     = PORT_W'($urandom);
        p.dport     = PORT_W'($urandom);
        p.src_mac   = {16'($urandom), $urandom};
        if (roll < 45) begin
            k = $urandom_range(HOST_POOL - 1);
            p.operation = OP_OUTBOUND;
            p.src_ip    = pool_host_ip[k];
            if ($urandom_range(3) != 0)
                p.src_mac = pool_host_mac[k];
            p.dst_ip    = pool_peer_ip[$urandom_range(PEER_POOL - 1)];
            p.dport     = pool_port[$urandom_range(PORT_POOL - 1)];
            recent_out[recent_wr] = p;
            recent_wr = (recent_wr + 1) % RECENT;
        end
        else if (roll < 70) begin
            // reply to a recent outbound word
            q = recent_out[$urandom_range(RECENT - 1)];
            p.protocol = q.protocol;
            p.src_ip   = q.dst_ip;
            p.sport    = q.dport;
            p.dst_ip   = q.src_ip;
            p.dport    = q.sport;
        end
        else if (roll < 90) begin
            p.src_ip   = pool_peer_ip[$urandom_range(PEER_POOL - 1)];
            p.sport    = pool_port[$urandom_range(PORT_POOL - 1)];
            if ($urandom_range(3) != 0)
                p.dst_ip = pool_host_ip[$urandom_range(HOST_POOL - 1)];
        end
        else begin
            p.operation = 1'($urandom_range(1));
            p.protocol  = PROTO_W'($urandom_range(255));
        end
        return p;
    endfunction

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_pkt(input pkt_in_t p, input bit typed, input pkt_out_t want);
        int target;
        target = n_taken + 1;
        start     <= 1'b1;
        request   <= p;
        req_typed <= typed;
        req_want  <= want;
        do @(negedge clk); while (n_taken != target);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic load_settings(input int ph);
        cfg_reg_t         regs [4];
        logic [CFG_W-1:0] v;
        int               target;
        regs = '{CFG_OWN_MAC, CFG_OWN_IP, CFG_GATEWAY_MAC, CFG_REPLY_SRC_MAC};
        for (int i = 0; i < $size(regs); i++) begin
            if (ph == 0)
                v = '1;
            else if (ph == PHASES - 1)
                v = '0;
            else
                v = {16'($urandom), $urandom};
            target = n_cfg + 1;
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= v;
            do @(negedge clk); while (n_cfg != target);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic flag(input string what, input logic [63:0] want_v,
                        input logic [63:0] got_v);
        n_bad++;
        if (n_bad <= 10)
            $display("mismatch on %s, word %0d: expected %h, got %h",
                     what, n_done, want_v, got_v);
    endtask

    always @(posedge clk) begin : monitor
        pkt_out_t want;
        pkt_out_t guess;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_OWN_MAC:       cur_own_mac     = cfg_data;
                    CFG_OWN_IP:        cur_own_ip      = cfg_data[IP_W-1:0];
                    CFG_GATEWAY_MAC:   cur_gateway_mac = cfg_data;
                    CFG_REPLY_SRC_MAC: cur_reply_mac   = cfg_data;
                    default: ;
                endcase
                n_cfg++;
            end
            if (start && !busy) begin
                guess = track_packet(request);
                expected_q.push_back(req_typed ? req_want : guess);
                n_taken++;
            end
            if (done) begin
                n_done++;
                status_seen[result.status]++;
                if (result.forward === 1'b1)
                    n_fwd++;
                if (expected_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result word %0d arrived with nothing pending", n_done);
                end
                else begin
                    want = expected_q.pop_front();
                    if (result.forward !== want.forward)
                        flag("forward", 64'(want.forward), 64'(result.forward));
                    if (result.out_dst_mac !== want.out_dst_mac)
                        flag("out_dst_mac", 64'(want.out_dst_mac), 64'(result.out_dst_mac));
                    if (result.out_src_mac !== want.out_src_mac)
                        flag("out_src_mac", 64'(want.out_src_mac), 64'(result.out_src_mac));
                    if (result.out_src_ip !== want.out_src_ip)
                        flag("out_src_ip", 64'(want.out_src_ip), 64'(result.out_src_ip));
                    if (result.status !== want.status)
                        flag("status", 64'(want.status), 64'(result.status));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("no handshake for %0d cycles, %0d words outstanding",
                         quiet_cycles, expected_q.size());
                $display("status: fail");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int idle_pct [PHASES];
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        req_typed = 1'b0;
        req_want  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OWN_MAC;
        cfg_data  = '0;
        idle_pct  = '{0, 47, 8};
        for (int i = 0; i < CONNS; i++)
            flow_live[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;

        // directed words, reset settings
        add_step(mk_pkt(OP_INBOUND, PROTO_TCP, PEER_IP, HOST_A, 16'd443, 16'd5000, '0),
                 1, drop_word(ST_NO_CLIENT));
        add_step(mk_pkt(OP_OUTBOUND, PROTO_TCP, HOST_A, PEER_IP, 16'd5000, 16'd443, MAC_A),
                 1, fwd_word(GATEWAY_MAC_RST, OWN_MAC_RST, ST_NEW_CLIENT));
        add_step(mk_pkt(OP_OUTBOUND, PROTO_TCP, HOST_A, PEER_IP, 16'd5000, 16'd443, MAC_A),
                 1, fwd_word(GATEWAY_MAC_RST, OWN_MAC_RST, ST_EXISTING));
        add_step(mk_pkt(OP_INBOUND, PROTO_TCP, PEER_IP, HOST_A, 16'd443, 16'd5000, '0),
                 1, fwd_word(MAC_A, REPLY_MAC_RST, ST_EXISTING));
        add_step(mk_pkt(OP_INBOUND, PROTO_TCP, PEER_IP, HOST_A, 16'd444, 16'd5000, '0),
                 1, drop_word(ST_NO_CONN));
        add_step(mk_pkt(OP_OUTBOUND, PROTO_UDP, HOST_A, PEER_IP, 16'd7, 16'd443, MAC_A),
                 0, '0);
        add_step(mk_pkt(OP_OUTBOUND, PROTO_ICMP, HOST_A, PEER_IP, '1, '1, MAC_A), 0, '0);
        add_step(mk_pkt(OP_INBOUND, PROTO_ICMP, PEER_IP, HOST_A, 16'h1234, 16'd9, '0), 0, '0);
        add_step(mk_pkt(OP_INBOUND, PROTO_TCP, PEER_IP, HOST_A, '0, '0, '0), 0, '0);
        add_step(mk_pkt(OP_OUTBOUND, 8'hFF, '1, '0, '0, '0, '1), 0, '0);
        add_step(mk_pkt(OP_OUTBOUND, PROTO_TCP, '0, '1, '1, '1, '0), 0, '0);
        add_step(mk_pkt(OP_INBOUND, PROTO_TCP, '1, '0, '1, '1, '1), 0, '0);
        add_step(mk_pkt(OP_INBOUND, 8'h00, '0, '1, 16'd7, 16'd7, '0), 0, '0);
        add_step(mk_pkt(OP_OUTBOUND, PROTO_TCP, HOST_A, PEER_IP, '0, 16'd80, MAC_A), 0, '0);
        add_step(mk_pkt(OP_OUTBOUND, PROTO_UDP, HOST_A, DNS_IP, 16'd40000, 16'd53, MAC_A),
                 0, '0);
        add_step(mk_pkt(OP_INBOUND, PROTO_UDP, DNS_IP, HOST_A, 16'd53, 16'd40000, '0), 0, '0);
        add_step(mk_pkt(OP_INBOUND, PROTO_UDP, DNS_IP, HOST_B, 16'd53, 16'd40000, '0),
                 1, drop_word(ST_NO_CLIENT));
        // known client with a new MAC keeps the stored one
        add_step(mk_pkt(OP_OUTBOUND, PROTO_TCP, '0, '1, 16'd1, '1, 48'h1234_5678_9ABC),
                 0, '0);
        add_step(mk_pkt(OP_INBOUND, PROTO_TCP, '1, '0, '1, '1, '0), 0, '0);
        add_step(mk_pkt(OP_INBOUND, PROTO_UDP, PEER_IP, HOST_A, 16'd443, 16'd5000, '0), 0, '0);

        for (int i = 0; i < HOST_POOL; i++) begin
            pool_host_ip[i]  = $urandom;
            pool_host_mac[i] = {16'($urandom), $urandom};
        end
        for (int i = 0; i < PEER_POOL; i++)
            pool_peer_ip[i] = $urandom;
        for (int i = 0; i < PORT_POOL; i++)
            pool_port[i] = PORT_W'($urandom);
        for (int i = 0; i < RECENT; i++) begin
            recent_out[i] = mk_pkt(OP_OUTBOUND, pick_protocol(),
                                   pool_host_ip[$urandom_range(HOST_POOL - 1)],
                                   pool_peer_ip[$urandom_range(PEER_POOL - 1)],
                                   PORT_W'($urandom), pool_port[$urandom_range(PORT_POOL - 1)],
                                   '0);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
            send_pkt(script[i].pkt, script[i].typed, script[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            // settings change only with the tracker idle
            drain();
            load_settings(ph);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_gap(idle_pct[ph]);
                send_pkt(random_packet(), 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d packets tracked, %0d forwarded, %0d register writes, %0d mismatches",
                 n_taken, n_fwd, n_cfg, n_bad);
        $display("outcomes: existing %0d, new conn %0d, new client %0d, client full %0d, %s",
                 status_seen[ST_EXISTING], status_seen[ST_NEW_CONN],
                 status_seen[ST_NEW_CLIENT], status_seen[ST_CLIENT_FULL],
                 $sformatf("conn full %0d, no client %0d, no conn %0d",
                           status_seen[ST_CONN_FULL], status_seen[ST_NO_CLIENT],
                           status_seen[ST_NO_CONN]));
        if (n_bad == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
